@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that check their own logic.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the outcome holds at the next clock edge.
`define ASSERT_NEXT(label, trig, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
// ---------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Holds the request and result codes, the command that is sent to every
// slot cell and the status that each cell shows to its neighbors.
// ---------------------------------------------------------------------------
package skt_pkg;

    // Field widths
    localparam int unsigned SKT_CAPACITY = 64;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned SIDX_W       = 6;
    localparam int unsigned CFG_W        = 7;
    localparam int unsigned POS_W        = 7;

    // Request operations
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_DEL_KEY = 2'd2;
    localparam logic [1:0] OP_DEL_IDX = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_DUP    = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_ABSENT = 2'd3;

    // Commands broadcast to the cell row
    localparam logic [2:0] CMD_HOLD    = 3'd0;
    localparam logic [2:0] CMD_CMP     = 3'd1;
    localparam logic [2:0] CMD_INS     = 3'd2;
    localparam logic [2:0] CMD_DEL_KEY = 3'd3;
    localparam logic [2:0] CMD_DEL_IDX = 3'd4;

    typedef struct packed {
        logic [2:0]        code;
        logic [KEY_W-1:0]  key;
        logic [SIDX_W-1:0] sidx;
    } skt_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             less;
        logic             eq;
        logic [KEY_W-1:0] key;
    } skt_slot_t;

endpackage

@@ rtl/skt_cell.sv @@
// ---------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one key and its valid flag, compares the key against a broadcast
// key, and on insert or delete takes the key of its left or right neighbor.
// ---------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  skt_cmd_t  cmd,
    input  skt_slot_t left,
    input  skt_slot_t right,
    output skt_slot_t slot
);

    localparam logic [31:0] INDEX_VEC = 32'(INDEX);

    logic             valid_reg, valid_next;
    logic             less_reg, less_next;
    logic             eq_reg, eq_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             at_pos;
    logic             from_pos;
    logic             from_idx;

    // This cell is the first one not below the key, or lies past it.
    assign at_pos   = !less_reg && left.less;
    assign from_pos = !less_reg;
    assign from_idx = INDEX_VEC >= {{(32 - SIDX_W){1'b0}}, cmd.sidx};

    // Compare, or shift by one slot in either direction.
    always_comb
    begin
        valid_next = valid_reg;
        less_next  = less_reg;
        eq_next    = eq_reg;
        key_next   = key_reg;
        case (cmd.code)
            CMD_CMP:
            begin
                less_next = valid_reg && ($signed(key_reg) < $signed(cmd.key));
                eq_next   = valid_reg && (key_reg == cmd.key);
            end
            CMD_INS:
            begin
                if (at_pos)
                begin
                    key_next   = cmd.key;
                    valid_next = 1'b1;
                end
                else if (from_pos)
                begin
                    key_next   = left.key;
                    valid_next = left.valid;
                end
            end
            CMD_DEL_KEY:
            begin
                if (from_pos)
                begin
                    key_next   = right.key;
                    valid_next = right.valid;
                end
            end
            CMD_DEL_IDX:
            begin
                if (from_idx)
                begin
                    key_next   = right.key;
                    valid_next = right.valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control flags are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            less_reg  <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            less_reg  <= less_next;
            eq_reg    <= eq_next;
        end
    end

    // The key itself only matters while the slot is valid.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign slot.valid = valid_reg;
    assign slot.less  = less_reg;
    assign slot.eq    = eq_reg;
    assign slot.key   = key_reg;

endmodule

@@ rtl/sorted_key_table_unit.sv @@
// ---------------------------------------------------------------------------
// sorted_key_table_unit: sorted table of unique signed 32-bit keys
// Requests arrive on the s_axis channel with the operation in tuser and the
// key and slot index in tdata. Each request gives one result on m_axis with
// the status in tuser and the position and new entry count in tdata.
// Lookup, insert, delete by key and delete by index are served.
// The cfg channel writes the table limit; it is always ready and is to be
// written only while no request is in flight.
// In the cycle a request is accepted every cell compares its key with the
// request key; in the EXEC state that follows, the row shifts by one slot
// and the result register that drives m_axis is loaded once the output
// register is free. No new request is accepted until this compare-then-shift
// pass over the cell row has finished.
// If the receiver stalls, the result is held; the next request is accepted
// and compared, then waits in the EXEC state until the result is taken.
// Reset empties the table and sets the limit to 64 keys.
// ---------------------------------------------------------------------------
module sorted_key_table_unit
    import skt_pkg::*;
#(
    parameter int unsigned CAPACITY = SKT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Request channel
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // key[31:0], slot_index[37:32], zero pad
    input  logic [1:0]       s_axis_tuser,   // op[1:0]
    // Result channel
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // position[6:0], entry_count[13:7], zero pad
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    // Table limit write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    `include "assert_macros.svh"

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CFG_W-1:0]  limit_reg;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_stat_reg, out_stat_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [POS_W-1:0]  out_cnt_reg, out_cnt_next;

    logic              accept;
    logic              commit;
    skt_cmd_t          cmd;
    logic [2:0]        action;
    skt_slot_t         slot_vec [CAPACITY];
    skt_slot_t         left_vec [CAPACITY];
    skt_slot_t         right_vec[CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] less_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] bound_vec;
    logic [CNT_W-1:0]  pos_enc;
    logic              found;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  cnt_new_ext;
    logic [CMP_W-1:0]  lim_ext;
    logic [CMP_W-1:0]  sidx_ext;
    logic              full;

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    // Neighbor links of the cell row, with fixed ends.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = slot_vec[i].valid;
            less_vec[i]  = slot_vec[i].less;
            eq_vec[i]    = slot_vec[i].eq;
            if (i == 0)
            begin
                left_vec[i] = '{valid: 1'b0, less: 1'b1, eq: 1'b0, key: '0};
            end
            else
            begin
                left_vec[i] = slot_vec[i-1];
            end
            if (i == CAPACITY - 1)
            begin
                right_vec[i] = '{valid: 1'b0, less: 1'b0, eq: 1'b0, key: '0};
            end
            else
            begin
                right_vec[i] = slot_vec[i+1];
            end
        end
    end

    // The cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        skt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_vec[g]),
            .right (right_vec[g]),
            .slot  (slot_vec[g])
        );
    end

    // Insertion point: first cell that is not below the key, or CAPACITY when the last cell is below it.
    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            bound_vec[i] = !less_vec[i] && ((i == 0) || less_vec[(i == 0) ? 0 : i - 1]);
            if (bound_vec[i])
            begin
                pos_enc = pos_enc | CNT_W'(i);
            end
        end
        if (less_vec[CAPACITY-1])
        begin
            pos_enc = CNT_W'(CAPACITY);
        end
    end

    assign found    = |eq_vec;
    assign pos_ext  = CMP_W'(pos_enc);
    assign cnt_ext  = CMP_W'(count_reg);
    assign lim_ext  = CMP_W'(limit_reg);
    assign sidx_ext = CMP_W'(sidx_reg);
    assign full     = (cnt_ext >= lim_ext) || (cnt_ext >= CMP_W'(CAPACITY));

    // Decide the result and the row update for the request in hand.
    always_comb
    begin
        action        = CMD_HOLD;
        count_next    = count_reg;
        out_stat_next = STAT_ABSENT;
        out_pos_next  = pos_ext[POS_W-1:0];
        case (op_reg)
            OP_LOOKUP:
            begin
                out_stat_next = found ? STAT_DUP : STAT_ABSENT;
            end
            OP_INSERT:
            begin
                if (found)
                begin
                    out_stat_next = STAT_DUP;
                end
                else if (full)
                begin
                    out_stat_next = STAT_FULL;
                    out_pos_next  = '0;
                end
                else
                begin
                    out_stat_next = STAT_DONE;
                    action        = CMD_INS;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_DEL_KEY:
            begin
                if (found)
                begin
                    out_stat_next = STAT_DONE;
                    action        = CMD_DEL_KEY;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_DEL_IDX:
            begin
                out_pos_next = POS_W'(sidx_reg);
                if (sidx_ext < cnt_ext)
                begin
                    out_stat_next = STAT_DONE;
                    action        = CMD_DEL_IDX;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        cnt_new_ext  = CMP_W'(count_next);
        out_cnt_next = cnt_new_ext[POS_W-1:0];
    end

    // Command to the row: compare on accept, send the update action on commit.
    always_comb
    begin
        cmd.code = CMD_HOLD;
        cmd.key  = key_reg;
        cmd.sidx = sidx_reg;
        if (accept)
        begin
            cmd.code = CMD_CMP;
            cmd.key  = s_axis_tdata[KEY_W-1:0];
        end
        else if (commit)
        begin
            cmd.code = action;
        end
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            limit_reg     <= CFG_W'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_axis_tuser;
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            sidx_reg <= s_axis_tdata[KEY_W+SIDX_W-1:KEY_W];
        end
        if (commit)
        begin
            out_stat_reg <= out_stat_next;
            out_pos_reg  <= out_pos_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tdata  = {2'b00, out_cnt_reg, out_pos_reg};

    // Self checks
    `ASSERT_ALWAYS(a_count_matches_row, CNT_W'($countones(valid_vec)) == count_reg,
        "valid slots disagree with the entry count")
    `ASSERT_ALWAYS(a_less_thermometer,
        (state_reg == ST_IDLE) || (((less_vec + CAPACITY'(1)) & less_vec) == '0),
        "slots below the key are not a prefix of the row")
    `ASSERT_ALWAYS(a_single_match, $onehot0(eq_vec), "more than one slot holds the key")
    `ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC,
        "accepted request did not reach the update cycle")

endmodule
